// File: src/upc_pkg.sv
// types and constants shared by the unordered pair occurrence counter
// no dependencies; imported by upc_cell and unordered_pair_occurrence_counter
package upc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int OCC_WIDTH   = 16;
   localparam int CAP_WIDTH   = 5;
   localparam int FILL_WIDTH  = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_WIDTH   = (FILL_WIDTH > CAP_WIDTH) ? FILL_WIDTH : CAP_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [CAP_WIDTH-1:0]   CAP_RESET = CAP_WIDTH'(16);
   localparam logic                   STATUS_OK       = 1'b0;
   localparam logic                   STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value_a;
      logic signed [VALUE_WIDTH-1:0] value_b;
      logic                          is_final;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] key_low;
      logic signed [VALUE_WIDTH-1:0] key_high;
      logic [OCC_WIDTH-1:0]          occurrences;
      logic                          is_last_entry;
      logic                          status;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] key_low;
      logic signed [VALUE_WIDTH-1:0] key_high;
      logic [COUNT_WIDTH-1:0]        count;
   } entry_type;

   // per-cell commands from the sequencer
   typedef struct packed {
      logic shift;
      logic bump;
      logic load_new;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

endpackage

// File: src/upc_cell.sv
// one cell of the key table: holds an entry, matches it against the broadcast key
// depends on upc_pkg
module upc_cell (
   input  logic                      clock,
   input  upc_pkg::cell_ctl_type     ctl,
   input  upc_pkg::entry_type        next_entry,
   input  logic signed [31:0]        key_low,
   input  logic signed [31:0]        key_high,
   input  logic                      occupied,
   output logic                      hit,
   output upc_pkg::entry_type        entry
);
   import upc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign hit   = occupied && (entry_ff.key_low == key_low) && (entry_ff.key_high == key_high);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load_new) begin
         entry_in.key_low  = key_low;
         entry_in.key_high = key_high;
         entry_in.count    = COUNT_WIDTH'(1);
      end else if (ctl.bump && hit) begin
         // saturating count
         if (entry_ff.count != COUNT_MAX) begin
            entry_in.count = entry_ff.count + COUNT_WIDTH'(1);
         end
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/unordered_pair_occurrence_counter.sv
// top level of the unordered pair occurrence counter: sequencer, cell chain, output register
// depends on upc_pkg and upc_cell
//
//  port group   direction  handshake          payload
//  req_         in         req_valid/ready    upc_pkg::req_type (value_a, value_b, is_final)
//  rsp_         out        rsp_valid/ready    upc_pkg::rsp_type (keys, count, last, status)
//  csr_         in         csr_wr_en only     capacity_limit, 5 bits
//
// a request first registers its ordered key (ST_IDLE), then all cells compare it in parallel
// (ST_LOOKUP) and the hit cell counts up, the next free cell loads it, or with no room the run overflows
// a final request then drains the table through the cell chain into the output
// register, one entry per cycle while rsp_ready is high (a single overflow status response if overflowed)
// synchronous active high reset clears fill count, overflow flag, state and response valid, and sets capacity to 16
// stored entries are not cleared; only cells below the fill count are ever looked at
// a stalled response holds the chain; a new request is taken once the last entry is loaded
module unordered_pair_occurrence_counter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  upc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output upc_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);
   import upc_pkg::*;

   // sequencer state
   state_type                     state_ff, state_in;
   logic [FILL_WIDTH-1:0]         used_ff, used_in;
   logic [FILL_WIDTH-1:0]         left_ff, left_in;
   logic                          ovf_ff, ovf_in;
   logic [CAP_WIDTH-1:0]          cap_ff;

   // ordered key of the request in flight
   logic signed [VALUE_WIDTH-1:0] key_low_ff, key_low_in;
   logic signed [VALUE_WIDTH-1:0] key_high_ff, key_high_in;
   logic                          final_ff, final_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   // cell chain
   entry_type                     entries [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]        hits;
   logic [TABLE_DEPTH-1:0]        occupied;
   cell_ctl_type                  cell_ctl [TABLE_DEPTH];

   logic                          do_update;
   logic                          do_insert;
   logic                          do_shift;
   logic                          any_hit;
   logic                          room;

   assign any_hit = |hits;
   // room for another key: below the table depth and below the programmed limit
   assign room = (used_ff < FILL_WIDTH'(TABLE_DEPTH)) &&
                 (LIM_WIDTH'(used_ff) < LIM_WIDTH'(cap_ff));

   genvar k;
   generate
      for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
         entry_type nxt;
         if (k == TABLE_DEPTH - 1) begin : g_tail
            assign nxt = entries[k];
         end else begin : g_body
            assign nxt = entries[k + 1];
         end

         assign occupied[k]       = FILL_WIDTH'(k) < used_ff;
         assign cell_ctl[k].shift    = do_shift;
         assign cell_ctl[k].bump     = do_update;
         assign cell_ctl[k].load_new = do_insert && (used_ff == FILL_WIDTH'(k));

         upc_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[k]),
            .next_entry (nxt),
            .key_low    (key_low_ff),
            .key_high   (key_high_ff),
            .occupied   (occupied[k]),
            .hit        (hits[k]),
            .entry      (entries[k])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      left_in      = left_ff;
      ovf_in       = ovf_ff;
      key_low_in   = key_low_ff;
      key_high_in  = key_high_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      do_update    = 1'b0;
      do_insert    = 1'b0;
      do_shift     = 1'b0;

      // response taken: valid drops unless a new one is loaded below
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // smaller signed value first
               if (req_data.value_b < req_data.value_a) begin
                  key_low_in  = req_data.value_b;
                  key_high_in = req_data.value_a;
               end else begin
                  key_low_in  = req_data.value_a;
                  key_high_in = req_data.value_b;
               end
               final_in = req_data.is_final;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            // an overflowed run ignores request keys; a final request still starts the emit
            if (!ovf_ff) begin
               if (any_hit) begin
                  do_update = 1'b1;
               end else if (room) begin
                  do_insert = 1'b1;
                  used_in   = used_ff + FILL_WIDTH'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (final_ff) begin
               left_in  = ovf_in ? FILL_WIDTH'(1) : used_in;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  rsp_in.key_low       = '0;
                  rsp_in.key_high      = '0;
                  rsp_in.occurrences   = '0;
                  rsp_in.is_last_entry = 1'b1;
                  rsp_in.status        = STATUS_OVERFLOW;
               end else begin
                  // head cell goes out, the rest move one place down
                  rsp_in.key_low       = entries[0].key_low;
                  rsp_in.key_high      = entries[0].key_high;
                  rsp_in.occurrences   = OCC_WIDTH'(entries[0].count);
                  rsp_in.is_last_entry = (left_ff == FILL_WIDTH'(1));
                  rsp_in.status        = STATUS_OK;
                  do_shift             = 1'b1;
               end
               left_in = left_ff - FILL_WIDTH'(1);
               if (left_ff == FILL_WIDTH'(1)) begin
                  used_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         left_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         left_ff      <= left_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      key_low_ff  <= key_low_in;
      key_high_ff <= key_high_in;
      final_ff    <= final_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/tb_unordered_pair_occurrence_counter.sv
// self-checking testbench for unordered_pair_occurrence_counter: directed and random pair sets
// depends on upc_pkg and the counter rtl; an in-bench tally table predicts every table dump
`timescale 1ns / 100ps

module tb_unordered_pair_occurrence_counter;

   import upc_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned RANDOM_ITEMS  = 150;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam logic signed [VALUE_WIDTH-1:0] VMIN = 32'h8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VMAX = 32'h7fff_ffff;

   // tally table kept alongside the block, plus the queue of table entries still owed
   class pair_tally_board;
      entry_type   tally[TABLE_DEPTH];
      int unsigned fill;
      bit          overflowed;
      int unsigned capacity;
      rsp_type     owed[$];
      int unsigned mismatches;

      function new();
         fill       = 0;
         overflowed = 1'b0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      // fold one accepted request into the table; a final request queues the dump
      function void note_request(req_type r);
         logic signed [VALUE_WIDTH-1:0] lo, hi;
         int unsigned limit, k;
         bit hit;
         rsp_type entry;
         if (!overflowed) begin
            lo = r.value_a;
            hi = r.value_b;
            if (r.value_b < r.value_a) begin
               lo = r.value_b;
               hi = r.value_a;
            end
            hit = 1'b0;
            for (k = 0; k < fill; k++) begin
               if (!hit && tally[k].key_low == lo && tally[k].key_high == hi) begin
                  hit = 1'b1;
                  if (tally[k].count != COUNT_MAX) tally[k].count++;
               end
            end
            if (!hit) begin
               limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
               if (fill >= limit) begin
                  overflowed = 1'b1;
               end else begin
                  tally[fill].key_low  = lo;
                  tally[fill].key_high = hi;
                  tally[fill].count    = COUNT_WIDTH'(1);
                  fill++;
               end
            end
         end
         if (r.is_final) begin
            if (overflowed) begin
               entry               = '0;
               entry.is_last_entry = 1'b1;
               entry.status        = STATUS_OVERFLOW;
               owed.push_back(entry);
            end else begin
               for (k = 0; k < fill; k++) begin
                  entry.key_low       = tally[k].key_low;
                  entry.key_high      = tally[k].key_high;
                  entry.occurrences   = OCC_WIDTH'(tally[k].count);
                  entry.is_last_entry = (k + 1 == fill);
                  entry.status        = STATUS_OK;
                  owed.push_back(entry);
               end
            end
            fill       = 0;
            overflowed = 1'b0;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 60) $display("mismatch: %s", what);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("response (%0d, %0d) x%0d with nothing expected",
                                      got.key_low, got.key_high, got.occurrences));
         end else begin
            want = owed.pop_front();
            if (got.key_low !== want.key_low)
               report_mismatch($sformatf("key_low %0d, expected %0d",
                                         got.key_low, want.key_low));
            if (got.key_high !== want.key_high)
               report_mismatch($sformatf("key_high %0d, expected %0d",
                                         got.key_high, want.key_high));
            if (got.occurrences !== want.occurrences)
               report_mismatch($sformatf("occurrences %0d, expected %0d",
                                         got.occurrences, want.occurrences));
            if (got.is_last_entry !== want.is_last_entry)
               report_mismatch($sformatf("is_last_entry %b, expected %b",
                                         got.is_last_entry, want.is_last_entry));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
         end
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = '0;

   pair_tally_board board = new();
   int unsigned     cycle_count = 0;
   bit              long_hold_req = 1'b0;   // sender asks the receiver for one long stall

   unordered_pair_occurrence_counter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // responses are taken at the edge where valid and ready were both high before it
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // extremes, small values near zero (so keys repeat and tie) and full-range noise
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return VMIN;
         1:       return VMAX;
         2, 3:    return VALUE_WIDTH'($signed($urandom_range(0, 7)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // capacity settings with the extremes and the above-depth values well represented
   function automatic logic [4:0] pick_capacity();
      case ($urandom_range(0, 7))
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd16;
         3:       return 5'd31;
         default: return 5'($urandom_range(2, 20));
      endcase
   endfunction

   // response side: random stalls, steady stretches, and the one long hold-off on request
   initial begin : rsp_side
      int unsigned hold;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else begin
            hold = pick_gap();
            if (hold != 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one request after an optional gap; returns just after the accepting edge
   task automatic offer(input logic signed [VALUE_WIDTH-1:0] a,
                        input logic signed [VALUE_WIDTH-1:0] b,
                        input bit fin, input bit gaps);
      req_type r;
      int unsigned gap;
      r.value_a  = a;
      r.value_b  = b;
      r.is_final = fin;
      gap = gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   // stop offering and let every owed entry come out, then a settling wait for the sequencer
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_capacity(input logic [4:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.capacity = cap;
   endtask

   // random sets: mostly well-formed (distinct keys within capacity, then repeats),
   // some deliberately overflowing, a few pure noise; each set ends with a final request
   task automatic run_random_sets(input int unsigned target);
      int unsigned sent, set_no, limit, n_keys, len, i, kind, pick;
      logic signed [VALUE_WIDTH-1:0] pool_a[$];
      logic signed [VALUE_WIDTH-1:0] pool_b[$];
      logic signed [VALUE_WIDTH-1:0] a, b, t;
      bit gaps;
      sent   = 0;
      set_no = 0;
      // the first sets go in while the receiver holds off, so the
      // output side fills and the request side must stall
      long_hold_req = 1'b1;
      while (sent < target) begin
         if (set_no >= 4 && $urandom_range(0, 3) == 0) begin
            wait_for_drain();
            write_capacity(pick_capacity());
         end else if (set_no == 9) begin
            wait_for_drain();   // sender pauses until everything owed has come out
         end
         limit = (board.capacity > TABLE_DEPTH) ? TABLE_DEPTH : board.capacity;
         kind  = $urandom_range(0, 9);
         gaps  = ($urandom_range(0, 3) != 0);
         pool_a.delete();
         pool_b.delete();
         if (kind <= 6) n_keys = (limit == 0) ? 1 : $urandom_range(1, limit);
         else if (kind <= 8) n_keys = limit + $urandom_range(1, 3);
         else n_keys = 0;
         for (i = 0; i < n_keys; i++) begin
            pool_a.push_back(pick_value());
            pool_b.push_back(pick_value());
         end
         len = (n_keys == 0) ? $urandom_range(1, 6) : n_keys + $urandom_range(0, 10);
         for (i = 0; i < len; i++) begin
            if (n_keys == 0) begin
               a = $urandom;
               b = $urandom;
            end else begin
               // every key once in order, then random repeats
               pick = (i < n_keys) ? i : $urandom_range(0, n_keys - 1);
               a = pool_a[pick];
               b = pool_b[pick];
            end
            if ($urandom_range(0, 1) == 1) begin
               t = a;
               a = b;
               b = t;
            end
            offer(a, b, i == len - 1, gaps);
            // requests swallowed after an overflow do not count toward the total
            if (kind <= 6 || kind == 9 || i <= limit) sent++;
         end
         set_no++;
      end
   endtask

   initial begin : stimulus
      int unsigned n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_capacity(CAP_RESET);

      // mirrored pairs, equal members, the signed extremes; final request is a new key
      offer(VMIN, VMAX, 1'b0, 1'b1);
      offer(VMAX, VMIN, 1'b0, 1'b1);
      offer(0, 0, 1'b0, 1'b1);
      offer(-1, 1, 1'b0, 1'b1);
      offer(1, -1, 1'b0, 1'b1);
      offer(VMIN, VMIN, 1'b0, 1'b1);
      offer(VMAX, VMAX, 1'b1, 1'b1);
      // a set made of a final request alone
      offer(5, -5, 1'b1, 1'b1);
      wait_for_drain();

      // capacity one: second key overflows, later requests and the final are swallowed
      write_capacity(5'd1);
      offer(1, 2, 1'b0, 1'b1);
      offer(3, 4, 1'b0, 1'b1);
      offer(2, 1, 1'b1, 1'b1);
      wait_for_drain();

      // capacity zero: the very first key overflows
      write_capacity(5'd0);
      offer(9, 9, 1'b1, 1'b1);
      wait_for_drain();

      // capacity above the table depth acts as the depth: 17 distinct keys overflow
      write_capacity(5'd31);
      for (n = 1; n <= 17; n++) offer(n, -n, n == 17, 1'b1);
      wait_for_drain();

      run_random_sets(RANDOM_ITEMS);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));
      if (board.mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
